// ----- sv/set_assoc_fifo_cache_tracker_assert.svh -----
// Assertion macros shared by the cache tracker modules.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef SET_ASSOC_FIFO_CACHE_TRACKER_ASSERT_SVH
`define SET_ASSOC_FIFO_CACHE_TRACKER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define SAFCT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache tracker check failed");

// Consequent checked in the cycle after the antecedent
`define SAFCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache tracker check failed");

`endif

// ----- sv/safct_pkg.sv -----
package safct_pkg;

  // Default geometry
  localparam int SETS_DEF      = 4;
  localparam int WAYS_DEF      = 4;
  localparam int ADDR_BITS_DEF = 16;

  // Fixed field widths
  localparam int COST_W    = 8;
  localparam int TOTAL_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIT_COST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_COST = 2'd1;

  // Register reset values
  localparam logic [COST_W-1:0] HIT_COST_RST  = 8'd1;
  localparam logic [COST_W-1:0] MISS_COST_RST = 8'd100;

  // Per-slot control from its set
  typedef struct packed {
    logic occupied;   // slot index below the set fill count
    logic load_new;   // store the incoming address
    logic take_next;  // take the neighbour's address (FIFO shift)
  } cell_ctl_t;

  // Per-set control from the top level
  typedef struct packed {
    logic sel;        // address maps to this set
    logic accept;     // a beat is taken this cycle
  } set_ctl_t;

  // Per-set status back to the top level
  typedef struct packed {
    logic hit;        // selected and a stored address matches
    logic full;       // all ways occupied
  } set_sts_t;

endpackage

// ----- sv/safct_cell.sv -----
module safct_cell #(
  parameter int ADDR_BITS = safct_pkg::ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  safct_pkg::cell_ctl_t  ctl,
  input  logic [ADDR_BITS-1:0]  new_addr,
  input  logic [ADDR_BITS-1:0]  next_addr,
  output logic [ADDR_BITS-1:0]  stored_addr,
  output logic                  match
);

  logic [ADDR_BITS-1:0] addr_r;

  // Slot storage: load a new tag or shift in from the younger neighbour
  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      addr_r <= new_addr;
    end else if (ctl.take_next) begin
      addr_r <= next_addr;
    end
  end

  // Tag compare, only for occupied slots
  assign match       = ctl.occupied && (addr_r == new_addr);
  assign stored_addr = addr_r;

endmodule

// ----- sv/safct_set.sv -----
module safct_set #(
  parameter int WAYS      = safct_pkg::WAYS_DEF,
  parameter int ADDR_BITS = safct_pkg::ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  safct_pkg::set_ctl_t   ctl,
  input  logic [ADDR_BITS-1:0]  address,
  output safct_pkg::set_sts_t   sts
);

  `include "set_assoc_fifo_cache_tracker_assert.svh"

  localparam int FILL_W = $clog2(WAYS + 1);

  logic [FILL_W-1:0]    fill_r;
  logic [FILL_W-1:0]    fill_nxt;
  logic [WAYS-1:0]      match;
  logic [ADDR_BITS-1:0] stored [WAYS];
  logic                 hit;
  logic                 full;
  logic                 miss_upd;
  logic                 cold_upd;
  logic                 shift_upd;

  assign hit       = ctl.sel && (|match);
  assign full      = (fill_r == FILL_W'(WAYS));
  assign miss_upd  = ctl.sel && ctl.accept && !(|match);
  assign cold_upd  = miss_upd && !full;
  assign shift_upd = miss_upd && full;

  // Row of slots, oldest at index 0
  for (genvar i = 0; i < WAYS; i++) begin : g_way
    safct_pkg::cell_ctl_t cctl;
    logic [ADDR_BITS-1:0] nbr;

    assign cctl.occupied = (FILL_W'(i) < fill_r);
    if (i == WAYS - 1) begin : g_last
      assign nbr            = address;
      assign cctl.load_new  = (cold_upd && (fill_r == FILL_W'(i))) || shift_upd;
      assign cctl.take_next = 1'b0;
    end else begin : g_mid
      assign nbr            = stored[i+1];
      assign cctl.load_new  = cold_upd && (fill_r == FILL_W'(i));
      assign cctl.take_next = shift_upd;
    end

    safct_cell #(
      .ADDR_BITS(ADDR_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (cctl),
      .new_addr   (address),
      .next_addr  (nbr),
      .stored_addr(stored[i]),
      .match      (match[i])
    );
  end

  // Fill count grows by one on each cold miss
  always_comb begin
    fill_nxt = fill_r;
    if (cold_upd) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign sts.hit  = hit;
  assign sts.full = full;

  // Fill count only ever steps up by one outside reset
  `SAFCT_ASSERT_SAME(a_fill_step, $past(rst_n) && (fill_r != $past(fill_r)), fill_r == $past(fill_r) + FILL_W'(1))

endmodule

// ----- sv/set_assoc_fifo_cache_tracker.sv -----
// Set-associative address tracker with FIFO replacement.
// Input channel: in_valid / in_stall with one address per beat. The set is
// (address * SETS) >> ADDR_BITS, the top bits for a power of two; the whole
// address is compared against that set's occupied ways combinationally. A
// miss in a set with a free way fills it (cold miss); a miss in a full set drops the oldest entry.
// Result channel: out_valid / out_stall, one beat per input beat, carrying
// hit, cold_miss and the saturating hit, miss and latency totals.
// The result is registered: it appears in the cycle after its address is taken.
// Throughput: one address per cycle while no result waits under out_stall;
// the lookup and the way update both finish in the accepting cycle, so the next address sees the new state.
// While out_stall holds a waiting result, in_stall is raised and no address
// is taken; the result and the cache state stay unchanged.
// Configuration: cfg_we writes hit_cost (index 0) or miss_cost (index 1);
// other indexes are ignored. Write only while the block is idle.
// Reset (rst_n low, synchronous): all sets empty, totals zero, hit_cost 1,
// miss_cost 100, no result pending. There is no clearing pass.
module set_assoc_fifo_cache_tracker #(
  parameter int SETS      = safct_pkg::SETS_DEF,
  parameter int WAYS      = safct_pkg::WAYS_DEF,
  parameter int ADDR_BITS = safct_pkg::ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [safct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [safct_pkg::COST_W-1:0]        cfg_wdata,
  // address beats
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ADDR_BITS-1:0]                in_address,
  // result beats
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic                                out_cold_miss,
  output logic [safct_pkg::TOTAL_W-1:0]       out_hit_total,
  output logic [safct_pkg::TOTAL_W-1:0]       out_miss_total,
  output logic [safct_pkg::TOTAL_W-1:0]       out_latency_total
);

  `include "set_assoc_fifo_cache_tracker_assert.svh"

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int PROD_W = ADDR_BITS + SET_W;
  localparam int TW     = safct_pkg::TOTAL_W;

  logic [safct_pkg::COST_W-1:0] hit_cost_r;
  logic [safct_pkg::COST_W-1:0] miss_cost_r;
  logic [TW-1:0]                hit_cnt_r, hit_cnt_nxt;
  logic [TW-1:0]                miss_cnt_r, miss_cnt_nxt;
  logic [TW-1:0]                lat_r, lat_nxt;
  logic                         out_valid_r;
  logic                         out_hit_r;
  logic                         out_cold_r;
  logic [TW-1:0]                out_hit_tot_r;
  logic [TW-1:0]                out_miss_tot_r;
  logic [TW-1:0]                out_lat_tot_r;

  logic                         accept;
  logic [PROD_W-1:0]            set_prod;
  logic [SET_W-1:0]             set_idx;
  logic [SETS-1:0]              hit_vec;
  logic [SETS-1:0]              full_vec;
  logic [SETS-1:0]              sel_vec;
  logic                         hit_any;
  logic                         full_sel;
  logic                         cold;
  logic [TW:0]                  cnt_sum;
  logic [TW:0]                  lat_sum;

  // Output register frees up when empty or being taken
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Set index: (address * SETS) >> ADDR_BITS, the top bits for a power of two
  assign set_prod = PROD_W'(in_address) * PROD_W'(SETS);
  assign set_idx  = set_prod[PROD_W-1:ADDR_BITS];

  // One chain of way slots per set
  for (genvar s = 0; s < SETS; s++) begin : g_set
    safct_pkg::set_ctl_t sctl;
    safct_pkg::set_sts_t ssts;

    assign sel_vec[s]  = (set_idx == SET_W'(s));
    assign sctl.sel    = sel_vec[s];
    assign sctl.accept = accept;
    assign hit_vec[s]  = ssts.hit;
    assign full_vec[s] = ssts.full;

    safct_set #(
      .WAYS     (WAYS),
      .ADDR_BITS(ADDR_BITS)
    ) u_set (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (sctl),
      .address(in_address),
      .sts    (ssts)
    );
  end

  assign hit_any  = |hit_vec;
  assign full_sel = |(full_vec & sel_vec);
  assign cold     = !hit_any && !full_sel;

  // Saturating totals
  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (hit_any) begin
      cnt_sum = {1'b0, hit_cnt_r} + (TW+1)'(1);
      lat_sum = {1'b0, lat_r} + (TW+1)'(hit_cost_r);
      hit_cnt_nxt = cnt_sum[TW] ? '1 : cnt_sum[TW-1:0];
    end else begin
      cnt_sum = {1'b0, miss_cnt_r} + (TW+1)'(1);
      lat_sum = {1'b0, lat_r} + (TW+1)'(miss_cost_r);
      miss_cnt_nxt = cnt_sum[TW] ? '1 : cnt_sum[TW-1:0];
    end
    lat_nxt = lat_sum[TW] ? '1 : lat_sum[TW-1:0];
  end

  // Counters and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      lat_r       <= '0;
      hit_cost_r  <= safct_pkg::HIT_COST_RST;
      miss_cost_r <= safct_pkg::MISS_COST_RST;
    end else begin
      if (accept) begin
        hit_cnt_r  <= hit_cnt_nxt;
        miss_cnt_r <= miss_cnt_nxt;
        lat_r      <= lat_nxt;
      end
      if (cfg_we && (cfg_index == safct_pkg::REG_HIT_COST)) begin
        hit_cost_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == safct_pkg::REG_MISS_COST)) begin
        miss_cost_r <= cfg_wdata;
      end
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_hit_r      <= hit_any;
      out_cold_r     <= cold;
      out_hit_tot_r  <= hit_cnt_nxt;
      out_miss_tot_r <= miss_cnt_nxt;
      out_lat_tot_r  <= lat_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_cold_miss     = out_cold_r;
  assign out_hit_total     = out_hit_tot_r;
  assign out_miss_total    = out_miss_tot_r;
  assign out_latency_total = out_lat_tot_r;

  // Only the selected set can report a hit
  `SAFCT_ASSERT_SAME(a_hit_onehot, 1'b1, $onehot0(hit_vec))
  // Every taken address produces a result in the next cycle
  `SAFCT_ASSERT_NEXT(a_accept_result, accept, out_valid_r)
  // The lookup outcome reaches the result beat
  `SAFCT_ASSERT_NEXT(a_hit_carried, accept, (out_hit_r == $past(hit_any)) && !(out_hit_r && out_cold_r))

endmodule
